// ===== rtl/core/prrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg
// Types and codes shared by the priority round-robin scheduler unit.
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam int IdW     = 4;
  localparam int PrioW   = 8;
  localparam int SliceW  = 16;
  localparam int StatusW = 3;
  localparam int QCountW = 5;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [IdW-1:0]   proc_id;
    logic [PrioW-1:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]     running_id;
    logic               running_valid;
    logic [SliceW-1:0]  slice_load;
    logic [StatusW-1:0] status;
    logic [QCountW-1:0] queue_count;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_RM_RD,
    S_RM_WR,
    S_RM_FIN,
    S_SC_MARK,
    S_SC_SUCC,
    S_SC_FIN,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/priority_round_robin_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one word at a time, set by the single-port queue RAM that every
//   scan and shift step goes through.
// Reset: queue empty, nothing running, time slice 1000; RAM contents are not
//   cleared.
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_unit
// Priority-sorted ready queue with round-robin service within each level.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_unit #(
  parameter int MAX_PROCS   = 16,
  parameter int PRIO_LEVELS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  prrs_pkg::cmd_t              cmd,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output prrs_pkg::rsp_t              rsp,
  input  logic                        cfg_we,
  input  logic [prrs_pkg::SliceW-1:0] cfg_wdata
);

  import prrs_pkg::*;

  localparam logic [SliceW-1:0] SliceReset = SliceW'(1000);

  logic [SliceW-1:0] time_slice;
  logic              core_idle;
  logic              res_valid;
  logic              res_take;
  rsp_t              res;

  prrs_core #(
    .MAX_PROCS   (MAX_PROCS),
    .PRIO_LEVELS (PRIO_LEVELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd_valid && !cmd_stall),
    .cmd        (cmd),
    .time_slice (time_slice),
    .res_take   (res_take),
    .idle       (core_idle),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign cmd_stall = !core_idle;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= SliceReset;
    end else if (cfg_we) begin
      time_slice <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule

// ===== rtl/core/prrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_ram
// Single-port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module prrs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/prrs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_core
// Ready queue sequencer: scans, shifts and schedules one queue entry per
// step through a single RAM port and one compare unit.
// ----------------------------------------------------------------------------
module prrs_core #(
  parameter int MAX_PROCS   = 16,
  parameter int PRIO_LEVELS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  prrs_pkg::cmd_t                cmd,
  input  logic [prrs_pkg::SliceW-1:0]   time_slice,
  input  logic                          res_take,
  output logic                          idle,
  output logic                          res_valid,
  output prrs_pkg::rsp_t                res
);

  import prrs_pkg::*;

  localparam int IdxW    = $clog2(MAX_PROCS);
  localparam int CntW    = $clog2(MAX_PROCS + 1);
  localparam int PrioTop = (PRIO_LEVELS - 1 > (1 << PrioW) - 1) ?
                           (1 << PrioW) - 1 : PRIO_LEVELS - 1;
  localparam logic [PrioW-1:0] PrioSat = PrioW'(PrioTop);
  localparam logic [CntW-1:0]  CntMax  = CntW'(MAX_PROCS);
  localparam logic [CntW-1:0]  CntOne  = CntW'(1);
  localparam logic [CntW-1:0]  CntTwo  = CntW'(2);

  state_t state, state_next;

  logic [CntW-1:0]  count, count_next;
  logic [IdxW-1:0]  mark, mark_next;
  logic [IdW-1:0]   running_id, running_id_next;
  logic             running_flag, running_flag_next;
  action_t          op_action, op_action_next;
  logic [IdW-1:0]   op_id, op_id_next;
  logic [PrioW-1:0] op_prio, op_prio_next;
  logic [CntW-1:0]  idx, idx_next;
  logic [CntW-1:0]  pos, pos_next;
  logic [IdxW-1:0]  hit, hit_next;
  logic             found, found_next;
  logic [PrioW-1:0] m_prio, m_prio_next;
  status_t          status, status_next;
  logic             sched_ok, sched_ok_next;

  logic             ram_we;
  logic [IdxW-1:0]  ram_addr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rbits;

  logic [CntW-1:0]  mark_ext;
  logic [CntW-1:0]  hit_ext;
  logic [CntW-1:0]  count_dec;
  logic [IdxW-1:0]  succ;
  logic [PrioW-1:0] cmd_prio;

  prrs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);
  assign mark_ext  = CntW'(mark);
  assign hit_ext   = CntW'(hit);
  assign count_dec = count - CntOne;
  assign succ      = (mark_ext + CntOne < count) ? mark + IdxW'(1) : '0;
  assign cmd_prio  = (cmd.priority_req > PrioSat) ? PrioSat : cmd.priority_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      mark         <= '0;
      running_id   <= '0;
      running_flag <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      mark         <= mark_next;
      running_id   <= running_id_next;
      running_flag <= running_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    op_action <= op_action_next;
    op_id     <= op_id_next;
    op_prio   <= op_prio_next;
    idx       <= idx_next;
    pos       <= pos_next;
    hit       <= hit_next;
    found     <= found_next;
    m_prio    <= m_prio_next;
    status    <= status_next;
    sched_ok  <= sched_ok_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    mark_next         = mark;
    running_id_next   = running_id;
    running_flag_next = running_flag;
    op_action_next    = op_action;
    op_id_next        = op_id;
    op_prio_next      = op_prio;
    idx_next          = idx;
    pos_next          = pos;
    hit_next          = hit;
    found_next        = found;
    m_prio_next       = m_prio;
    status_next       = status;
    sched_ok_next     = sched_ok;
    ram_we            = 1'b0;
    ram_addr          = idx[IdxW-1:0];
    ram_wdata         = ram_rdata;
    res_valid         = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_action_next = action_t'(cmd.action);
          op_id_next     = cmd.proc_id;
          op_prio_next   = cmd_prio;
          status_next    = ST_OK;
          sched_ok_next  = 1'b0;
          idx_next       = '0;
          pos_next       = count;
          found_next     = 1'b0;
          case (action_t'(cmd.action))
            ACT_INSERT, ACT_REMOVE: begin
              state_next = (count == '0) ? S_DECIDE : S_SCAN;
            end
            ACT_SCHEDULE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_DONE;
              end else begin
                state_next = S_SC_MARK;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (ram_rdata.id == op_id) begin
          found_next = 1'b1;
          hit_next   = idx[IdxW-1:0];
        end
        if (pos == count && ram_rdata.prio < op_prio) begin
          pos_next = idx;
        end
        idx_next   = idx + CntOne;
        state_next = (idx + CntOne == count) ? S_DECIDE : S_SCAN;
      end

      S_DECIDE: begin
        if (op_action == ACT_INSERT) begin
          if (found) begin
            status_next = ST_DUP;
            state_next  = S_DONE;
          end else if (count == CntMax) begin
            status_next = ST_FULL;
            state_next  = S_DONE;
          end else begin
            idx_next   = count;
            state_next = (count == pos) ? S_PUT : S_SH_RD;
          end
        end else begin
          if (!found) begin
            status_next = ST_NOT_FOUND;
            state_next  = S_DONE;
          end else begin
            idx_next   = hit_ext;
            state_next = (hit_ext + CntOne < count) ? S_RM_RD : S_RM_FIN;
          end
        end
      end

      S_SH_RD: begin
        ram_addr   = IdxW'(idx - CntOne);
        state_next = S_SH_WR;
      end

      S_SH_WR: begin
        ram_we     = 1'b1;
        ram_addr   = idx[IdxW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx - CntOne;
        state_next = (idx - CntOne == pos) ? S_PUT : S_SH_RD;
      end

      S_PUT: begin
        ram_we         = 1'b1;
        ram_addr       = pos[IdxW-1:0];
        ram_wdata.id   = op_id;
        ram_wdata.prio = op_prio;
        count_next     = count + CntOne;
        if (count == '0) begin
          mark_next = '0;
        end else if (pos <= mark_ext) begin
          mark_next = mark + IdxW'(1);
        end
        state_next = S_DONE;
      end

      S_RM_RD: begin
        ram_addr   = IdxW'(idx + CntOne);
        state_next = S_RM_WR;
      end

      S_RM_WR: begin
        ram_we     = 1'b1;
        ram_addr   = idx[IdxW-1:0];
        ram_wdata  = ram_rdata;
        idx_next   = idx + CntOne;
        state_next = (idx + CntTwo < count) ? S_RM_RD : S_RM_FIN;
      end

      S_RM_FIN: begin
        count_next = count_dec;
        if (hit < mark) begin
          mark_next = mark - IdxW'(1);
        end else if (hit == mark) begin
          mark_next = (hit_ext < count_dec) ? hit : '0;
        end
        state_next = S_DONE;
      end

      S_SC_MARK: begin
        ram_addr   = mark;
        state_next = S_SC_SUCC;
      end

      S_SC_SUCC: begin
        running_id_next   = ram_rdata.id;
        running_flag_next = 1'b1;
        m_prio_next       = ram_rdata.prio;
        ram_addr          = succ;
        state_next        = S_SC_FIN;
      end

      S_SC_FIN: begin
        mark_next     = (ram_rdata.prio < m_prio) ? '0 : succ;
        sched_ok_next = 1'b1;
        state_next    = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign idle              = (state == S_IDLE);
  assign res.running_id    = running_id;
  assign res.running_valid = running_flag;
  assign res.slice_load    = sched_ok ? time_slice : '0;
  assign res.status        = status;
  assign res.queue_count   = QCountW'(count);

endmodule

// ===== tb/tb_priority_round_robin_scheduler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_round_robin_scheduler_unit
// Drives insert, remove and schedule commands into the ready queue and checks
// every response word against a cycle-free model of the sorted queue, its
// round-robin mark and the running process. A directed opener covers the
// empty, duplicate, mark-wrap and running-removal cases. Random phases follow,
// each under its own time slice; some add sender gaps or receiver stalls.
// ----------------------------------------------------------------------------
module tb_priority_round_robin_scheduler_unit;
  import prrs_pkg::*;

  localparam int NUM_PROCS   = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 130;

  class ready_queue_tracker;
    logic [IdW-1:0]    ids[NUM_PROCS];
    logic [PrioW-1:0]  prios[NUM_PROCS];
    bit                marks[NUM_PROCS];
    int                count;
    logic [IdW-1:0]    run_id;
    bit                run_ok;
    logic [SliceW-1:0] slice;
    rsp_t              future_rsps[$];
    int                errors;

    function new();
      count  = 0;
      run_id = '0;
      run_ok = 1'b0;
      slice  = 16'd1000;
      errors = 0;
      foreach (marks[i]) begin
        marks[i] = 1'b0;
        ids[i]   = '0;
        prios[i] = '0;
      end
    endfunction

    function int pending();
      return future_rsps.size();
    endfunction

    function int find(logic [IdW-1:0] id);
      for (int i = 0; i < count; i++)
        if (ids[i] == id) return i;
      return count;
    endfunction

    function void apply_cmd(cmd_t c);
      status_t           st;
      logic [SliceW-1:0] load;
      rsp_t              w;
      int                pos;
      int                m;
      int                succ;
      bit                was_marked;
      st   = ST_OK;
      load = '0;
      case (c.action)
        ACT_INSERT: begin
          pos = find(c.proc_id);
          if (pos < count) st = ST_DUP;
          else if (count >= NUM_PROCS) st = ST_FULL;
          else begin
            pos = count;
            for (int i = 0; i < count; i++)
              if (prios[i] < c.priority_req) begin
                pos = i;
                break;
              end
            for (int i = count; i > pos; i--) begin
              ids[i]   = ids[i-1];
              prios[i] = prios[i-1];
              marks[i] = marks[i-1];
            end
            ids[pos]   = c.proc_id;
            prios[pos] = c.priority_req;
            marks[pos] = (count == 0);
            count++;
          end
        end
        ACT_REMOVE: begin
          pos = find(c.proc_id);
          if (pos >= count) st = ST_NOT_FOUND;
          else begin
            was_marked = marks[pos];
            for (int i = pos; i + 1 < count; i++) begin
              ids[i]   = ids[i+1];
              prios[i] = prios[i+1];
              marks[i] = marks[i+1];
            end
            count--;
            marks[count] = 1'b0;
            if (was_marked && count > 0) marks[(pos < count) ? pos : 0] = 1'b1;
          end
        end
        ACT_SCHEDULE: begin
          if (count == 0) st = ST_EMPTY;
          else begin
            m = 0;
            for (int i = count - 1; i >= 0; i--)
              if (marks[i]) m = i;
            run_id   = ids[m];
            run_ok   = 1'b1;
            succ     = (m + 1 < count) ? m + 1 : 0;
            marks[m] = 1'b0;
            if (prios[succ] < prios[m]) marks[0] = 1'b1;
            else marks[succ] = 1'b1;
            load = slice;
          end
        end
        default: ;
      endcase
      w.running_id    = run_id;
      w.running_valid = run_ok;
      w.slice_load    = load;
      w.status        = st;
      w.queue_count   = QCountW'(count);
      future_rsps.push_back(w);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_rsp(rsp_t r);
      rsp_t want;
      if (future_rsps.size() == 0) begin
        report("word with no command pending", 16'(r.status), '0);
        return;
      end
      want = future_rsps.pop_front();
      if (r.running_id !== want.running_id)
        report("running_id", 16'(r.running_id), 16'(want.running_id));
      if (r.running_valid !== want.running_valid)
        report("running_valid", 16'(r.running_valid), 16'(want.running_valid));
      if (r.slice_load !== want.slice_load)
        report("slice_load", r.slice_load, want.slice_load);
      if (r.status !== want.status)
        report("status", 16'(r.status), 16'(want.status));
      if (r.queue_count !== want.queue_count)
        report("queue_count", 16'(r.queue_count), 16'(want.queue_count));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  cmd_t              cmd;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              cfg_we;
  logic [SliceW-1:0] cfg_wdata;

  ready_queue_tracker tracker = new();
  int send_gap_pct = 0;
  int stall_pct    = 0;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int quiet        = 0;

  priority_round_robin_scheduler_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_rsp(rsp);
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else quiet <= quiet + 1;
  end

  function automatic cmd_t mk(action_t a, logic [IdW-1:0] id, logic [PrioW-1:0] p);
    cmd_t c;
    c.action       = a;
    c.proc_id      = id;
    c.priority_req = p;
    return c;
  endfunction

  function automatic logic [PrioW-1:0] pick_prio();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic cmd_t random_cmd(bit grow);
    cmd_t           c;
    int             r;
    int             ins_w;
    int             rem_w;
    int             start;
    logic [IdW-1:0] id;
    ins_w = grow ? 55 : 20;
    rem_w = grow ? 15 : 45;
    c.proc_id      = 4'($urandom_range(15));
    c.priority_req = pick_prio();
    r = $urandom_range(99);
    if (r < 3) c.action = ACT_NOP;
    else if (r < 3 + ins_w) begin
      c.action = ACT_INSERT;
      if ($urandom_range(9) < 8) begin
        start = $urandom_range(15);
        for (int k = 0; k < NUM_PROCS; k++) begin
          id = 4'((start + k) % NUM_PROCS);
          if (tracker.find(id) >= tracker.count) begin
            c.proc_id = id;
            break;
          end
        end
      end
    end else if (r < 3 + ins_w + rem_w) begin
      c.action = ACT_REMOVE;
      if (tracker.count > 0 && $urandom_range(9) < 8)
        c.proc_id = tracker.ids[$urandom_range(tracker.count - 1)];
    end else c.action = ACT_SCHEDULE;
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      cmd_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    tracker.apply_cmd(c);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_slice(input logic [SliceW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.slice = v;
  endtask

  initial begin
    logic [SliceW-1:0] slices[5];
    int                gaps[5];
    int                stalls[5];
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    slices = '{16'hffff, 16'h0000, 16'h0001, 16'($urandom_range(65535)),
               16'($urandom_range(65535, 1))};
    gaps   = '{0, 70, 0, 31, 0};
    stalls = '{0, 0, 70, 31, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd7, 8'h00));
    send_cmd(mk(ACT_NOP, 4'd15, 8'hff));
    send_cmd(mk(ACT_INSERT, 4'd3, 8'h80));
    send_cmd(mk(ACT_INSERT, 4'd3, 8'h10));
    send_cmd(mk(ACT_INSERT, 4'd9, 8'h80));
    send_cmd(mk(ACT_INSERT, 4'd0, 8'hff));
    send_cmd(mk(ACT_INSERT, 4'd15, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd0, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd15, 8'hff));
    send_cmd(mk(ACT_INSERT, 4'd5, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd9, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd5, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd3, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd15, 8'h00));
    send_cmd(mk(ACT_REMOVE, 4'd15, 8'h00));
    send_cmd(mk(ACT_SCHEDULE, 4'd0, 8'h00));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      send_gap_pct = gaps[ph];
      stall_pct    = stalls[ph];
      write_slice(slices[ph]);
      if (ph == 0) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_cmd(random_cmd(((n / 40) % 2) == 0));
    end

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
